// ===== rtl/pat_pkg.sv =====
package pat_pkg;

    localparam int MODE_W       = 2;
    localparam int COUNT_W      = 13;
    localparam int PID_W        = 4;
    localparam int PAGE_W       = 5;
    localparam int FRAME_IN_W   = 12;
    localparam int OFFSET_W     = 16;
    localparam int STATUS_W     = 3;
    localparam int ADDR_W       = 28;
    localparam int PSIZE_W      = 16;
    localparam int TPAGES_W     = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam int MAX_PROCESSES_DEF = 15;
    localparam int MAX_PAGES_DEF     = 16;
    localparam int FRAME_BITS_DEF    = 12;

    localparam logic [PSIZE_W-1:0]  PAGE_SIZE_RST   = 16'd4096;
    localparam logic [TPAGES_W-1:0] TOTAL_PAGES_RST = 13'd16;

    localparam logic [MODE_W-1:0] MODE_ADMIT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRANSLATE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES = 1'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_ADMIT   = 3'd1,
        ST_BAD_PROC   = 3'd2,
        ST_BAD_PAGE   = 3'd3,
        ST_BAD_OFFSET = 3'd4
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [PID_W-1:0]   assigned;
        logic               tbl_we;
        logic               xlate_ok;
    } chk_t;

endpackage

// ===== rtl/pat_if.sv =====
interface pat_in_if import pat_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [COUNT_W-1:0]    page_count;
    logic [PID_W-1:0]      process_id;
    logic [PAGE_W-1:0]     page_number;
    logic [FRAME_IN_W-1:0] frame_number;
    logic [OFFSET_W-1:0]   byte_offset;

    modport source (output valid, mode, page_count, process_id, page_number, frame_number,
                    byte_offset, input ready);
    modport sink   (input valid, mode, page_count, process_id, page_number, frame_number,
                    byte_offset, output ready);
endinterface

interface pat_out_if import pat_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    assigned_process;
    logic [ADDR_W-1:0]   physical_address;

    modport source (output valid, status, assigned_process, physical_address, input ready);
    modport sink   (input valid, status, assigned_process, physical_address, output ready);
endinterface

// ===== rtl/pat_proc_table.sv =====
module pat_proc_table import pat_pkg::*; #(
    parameter int MAX_PROCESSES         = MAX_PROCESSES_DEF,
    parameter int MAX_PAGES_PER_PROCESS = MAX_PAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [MODE_W-1:0]   mode,
    input  logic [COUNT_W-1:0]  page_count,
    input  logic [PID_W-1:0]    process_id,
    input  logic [PAGE_W-1:0]   page_number,
    input  logic [OFFSET_W-1:0] byte_offset,
    input  logic [PSIZE_W-1:0]  page_size,
    input  logic [TPAGES_W-1:0] total_pages,
    output chk_t                chk
);

    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
    localparam int PC_W  = $clog2(MAX_PAGES_PER_PROCESS + 1);
    localparam int CMP_W = (CNT_W > PID_W) ? CNT_W : PID_W;
    localparam int PG_W  = (PC_W > PAGE_W) ? PC_W : PAGE_W;

    logic [CNT_W-1:0]    admitted_count_reg, admitted_count_next;
    logic [COUNT_W-1:0]  used_pages_reg, used_pages_next;
    logic                closed_reg, closed_next;
    logic [PC_W-1:0]     page_counts_reg [0:MAX_PROCESSES];

    logic [COUNT_W-1:0]  free_pages;
    logic [CNT_W-1:0]    adm_inc;
    logic                admit_fail;
    logic [CMP_W-1:0]    pid_ext;
    logic                pid_bad;
    logic [PC_W-1:0]     cnt_sel;
    logic                page_bad;
    logic                off_bad;
    logic                admit_ok;

    always_comb
    begin
        free_pages = (used_pages_reg > total_pages) ? '0 : total_pages - used_pages_reg;
        adm_inc    = CNT_W'(admitted_count_reg + CNT_W'(1));
        admit_fail = closed_reg || (page_count > free_pages)
                     || (page_count > COUNT_W'(MAX_PAGES_PER_PROCESS))
                     || (admitted_count_reg == CNT_W'(MAX_PROCESSES));
        pid_ext    = CMP_W'(process_id);
        pid_bad    = (pid_ext == '0) || (pid_ext > CMP_W'(admitted_count_reg));
        cnt_sel    = page_counts_reg[pid_ext[CNT_W-1:0]];
        page_bad   = PG_W'(page_number) >= PG_W'(cnt_sel);
        off_bad    = byte_offset >= page_size;

        chk       = '0;
        admit_ok  = 1'b0;
        case (mode)
            MODE_ADMIT:
            begin
                if (admit_fail)
                begin
                    chk.status = ST_NO_ADMIT;
                end
                else
                begin
                    admit_ok     = 1'b1;
                    chk.status   = ST_OK;
                    chk.assigned = PID_W'(adm_inc);
                end
            end
            MODE_WRITE:
            begin
                if (pid_bad)
                    chk.status = ST_BAD_PROC;
                else if (page_bad)
                    chk.status = ST_BAD_PAGE;
                else
                begin
                    chk.status = ST_OK;
                    chk.tbl_we = 1'b1;
                end
            end
            MODE_TRANSLATE:
            begin
                if (pid_bad)
                    chk.status = ST_BAD_PROC;
                else if (page_bad)
                    chk.status = ST_BAD_PAGE;
                else if (off_bad)
                    chk.status = ST_BAD_OFFSET;
                else
                begin
                    chk.status   = ST_OK;
                    chk.xlate_ok = 1'b1;
                end
            end
            default:
            begin
                chk.status = ST_NO_ADMIT;
            end
        endcase

        admitted_count_next = admitted_count_reg;
        used_pages_next     = used_pages_reg;
        closed_next         = closed_reg;
        if (fire && (mode == MODE_ADMIT))
        begin
            if (admit_ok)
            begin
                admitted_count_next = adm_inc;
                used_pages_next     = COUNT_W'(used_pages_reg + page_count);
            end
            else
            begin
                closed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            admitted_count_reg <= '0;
            used_pages_reg     <= '0;
            closed_reg         <= 1'b0;
            for (int i = 0; i <= MAX_PROCESSES; i++)
                page_counts_reg[i] <= '0;
        end
        else
        begin
            admitted_count_reg <= admitted_count_next;
            used_pages_reg     <= used_pages_next;
            closed_reg         <= closed_next;
            if (fire && admit_ok)
                page_counts_reg[adm_inc] <= PC_W'(page_count);
        end
    end

endmodule

// ===== rtl/paged_address_translator_unit.sv =====
// Channel  Dir  Beat payload
// req      in   mode, page_count, process_id, page_number, frame_number, byte_offset
// rsp      out  status, assigned_process, physical_address
// cfg      in   cfg_we, cfg_index, cfg_wdata (write only)
//
// One beat per cycle on req while req.ready is high; each req beat gives exactly one rsp beat.
// Stage 1 checks the item and reads or writes the frame table, stage 2 does the
// frame * page_size + offset multiply-add, stage 3 is the output register.
// A stall on rsp holds every full stage while empty ones still fill; req.ready drops once all are full.
// Reset clears the process table and loads the config defaults; frame entries are not cleared.
module paged_address_translator_unit import pat_pkg::*; #(
    parameter int MAX_PROCESSES         = MAX_PROCESSES_DEF,
    parameter int MAX_PAGES_PER_PROCESS = MAX_PAGES_DEF,
    parameter int FRAME_BITS            = FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pat_in_if.sink                req,
    pat_out_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int TBL_DEPTH = (MAX_PROCESSES + 1) * MAX_PAGES_PER_PROCESS;
    localparam int TA_W      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int SUM_W     = FRAME_BITS + PSIZE_W + 1;

    logic [PSIZE_W-1:0]    page_size_reg;
    logic [TPAGES_W-1:0]   total_pages_reg;

    logic                  s1_valid_reg, s1_valid_next;
    logic [MODE_W-1:0]     s1_mode_reg;
    logic [COUNT_W-1:0]    s1_count_reg;
    logic [PID_W-1:0]      s1_pid_reg;
    logic [PAGE_W-1:0]     s1_page_reg;
    logic [FRAME_IN_W-1:0] s1_frame_reg;
    logic [OFFSET_W-1:0]   s1_offset_reg;

    logic                  s2_valid_reg, s2_valid_next;
    status_t               s2_status_reg;
    logic [PID_W-1:0]      s2_assigned_reg;
    logic                  s2_xlate_reg;
    logic [OFFSET_W-1:0]   s2_offset_reg;
    logic [FRAME_BITS-1:0] frame_rd_reg;

    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg;
    logic [PID_W-1:0]      out_assigned_reg;
    logic [ADDR_W-1:0]     out_addr_reg;

    logic [FRAME_BITS-1:0] frame_mem [TBL_DEPTH];

    logic                  out_load, s2_adv, s1_adv, s1_fire;
    chk_t                  chk;
    logic [TA_W-1:0]       tbl_addr;
    logic [SUM_W-1:0]      addr_full;

    always_comb
    begin
        out_load       = !out_valid_reg || rsp.ready;
        s2_adv         = !s2_valid_reg || out_load;
        s1_adv         = !s1_valid_reg || s2_adv;
        s1_fire        = s1_valid_reg && s2_adv;
        s1_valid_next  = s1_adv ? req.valid : s1_valid_reg;
        s2_valid_next  = s2_adv ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_load ? s2_valid_reg : out_valid_reg;
        tbl_addr       = TA_W'(TA_W'(s1_pid_reg) * TA_W'(MAX_PAGES_PER_PROCESS)
                         + TA_W'(s1_page_reg));
        addr_full      = SUM_W'(SUM_W'(frame_rd_reg) * SUM_W'(page_size_reg)
                         + SUM_W'(s2_offset_reg));
    end

    assign req.ready            = s1_adv;
    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.assigned_process = out_assigned_reg;
    assign rsp.physical_address = out_addr_reg;

    pat_proc_table #(
        .MAX_PROCESSES         (MAX_PROCESSES),
        .MAX_PAGES_PER_PROCESS (MAX_PAGES_PER_PROCESS)
    ) u_proc_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .mode        (s1_mode_reg),
        .page_count  (s1_count_reg),
        .process_id  (s1_pid_reg),
        .page_number (s1_page_reg),
        .byte_offset (s1_offset_reg),
        .page_size   (page_size_reg),
        .total_pages (total_pages_reg),
        .chk         (chk)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg   <= PAGE_SIZE_RST;
            total_pages_reg <= TOTAL_PAGES_RST;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PAGE_SIZE:   page_size_reg   <= PSIZE_W'(cfg_wdata);
                    REG_TOTAL_PAGES: total_pages_reg <= TPAGES_W'(cfg_wdata);
                    default:         page_size_reg   <= page_size_reg;
                endcase
            end
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_mode_reg   <= req.mode;
            s1_count_reg  <= req.page_count;
            s1_pid_reg    <= req.process_id;
            s1_page_reg   <= req.page_number;
            s1_frame_reg  <= req.frame_number;
            s1_offset_reg <= req.byte_offset;
        end
        if (s2_adv)
        begin
            s2_status_reg   <= chk.status;
            s2_assigned_reg <= chk.assigned;
            s2_xlate_reg    <= chk.xlate_ok;
            s2_offset_reg   <= s1_offset_reg;
        end
        if (out_load)
        begin
            out_status_reg   <= s2_status_reg;
            out_assigned_reg <= s2_assigned_reg;
            out_addr_reg     <= s2_xlate_reg ? ADDR_W'(addr_full) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && chk.tbl_we)
            frame_mem[tbl_addr] <= FRAME_BITS'(s1_frame_reg);
        if (s1_fire && chk.xlate_ok)
            frame_rd_reg <= frame_mem[tbl_addr];
    end

endmodule

// ===== rtl/pat_checker.sv =====
module pat_checker import pat_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [PID_W-1:0]    rsp_assigned,
    input logic [ADDR_W-1:0]   rsp_addr
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp beat dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_assigned)
                                    && $stable(rsp_addr))
        else $error("rsp payload changed while stalled");

    a_assign_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_assigned != '0) |-> rsp_status == ST_OK)
        else $error("process number given on a failed beat");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> rsp_addr == '0)
        else $error("address given on a failed beat");

    a_assign_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_assigned == '0) || (rsp_addr == '0))
        else $error("admission and translation results mixed");

endmodule

bind paged_address_translator_unit pat_checker u_pat_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_assigned (rsp.assigned_process),
    .rsp_addr     (rsp.physical_address)
);
